// ===== design/pfx_pkg.sv =====
// ----------------------------------------------------------------------------
// pfx_pkg: shared types and constants of the postfix evaluator
// token kinds, operator and status codes, word widths, saturation helpers
// ----------------------------------------------------------------------------
`default_nettype none

package pfx_pkg;

  localparam int WORD_W = 48;
  localparam int MAG_W  = 2 * WORD_W;

  localparam logic KIND_OPERAND  = 1'b0;
  localparam logic KIND_OPERATOR = 1'b1;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISSING  = 3'd1;
  localparam logic [2:0] ST_DIV_ZERO = 3'd2;
  localparam logic [2:0] ST_MOD_ZERO = 3'd3;
  localparam logic [2:0] ST_ILLEGAL  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;

  localparam logic [WORD_W-1:0] POS_LIMIT = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] NEG_LIMIT = {1'b1, {(WORD_W-1){1'b0}}};

  // control toward the shared shift/add unit
  typedef struct packed {
    logic start;
    logic mul;
  } pfx_req_t;

  // magnitude of a signed word, the most negative value maps to 2^47
  function automatic logic [WORD_W-1:0] mag_of(input logic [WORD_W-1:0] v);
    mag_of = v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
  endfunction

  // signed word from sign and wide magnitude, saturating
  function automatic logic [WORD_W-1:0] from_mag(input logic neg,
                                                  input logic [MAG_W-1:0] m);
    if (neg) begin
      if (m > MAG_W'(NEG_LIMIT)) from_mag = NEG_LIMIT;
      else from_mag = ~m[WORD_W-1:0] + WORD_W'(1);
    end else begin
      if (m > MAG_W'(POS_LIMIT)) from_mag = POS_LIMIT;
      else from_mag = m[WORD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/postfix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator: postfix token evaluator in Q32.16
// value stack in a memory, cached top of stack, shared shift/add unit for
// multiply, divide and modulo, first error latched per expression
// ----------------------------------------------------------------------------
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-----------------------------------
//  token    | token_valid  | token_stall  | kind, token_value, op_code,
//           |              |              | last_token
//  result   | result_valid | result_stall | result_value, status
//
//  steps per token: push S_IDLE, S_FIN; add/sub S_IDLE, S_OPND, S_FIN;
//  multiply and nonzero divide/modulo add S_WAIT on the bit-serial loop of
//  pfx_shift_unit; after a latched error, every token takes S_IDLE, S_FIN
//  token_stall is high from the request until the token is fully retired
//  a last token waits in the final state while the result register is stalled
//  rst is synchronous; the stack memory has no reset, only the count clears
//
`default_nettype none

module postfix_expression_evaluator
  import pfx_pkg::*;
#(
  parameter int STACK_DEPTH   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              token_valid,
  output logic                   token_stall,
  input  wire logic              kind,
  input  wire logic [WORD_W-1:0] token_value,
  input  wire logic [2:0]        op_code,
  input  wire logic              last_token,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic [WORD_W-1:0]      result_value,
  output logic [2:0]             status
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int NUM_W = WORD_W + FRACTION_BITS;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // ready for a token
  localparam logic [1:0] S_OPND = 2'd1;  // lower operand arrives from memory
  localparam logic [1:0] S_WAIT = 2'd2;  // shared unit iterating
  localparam logic [1:0] S_FIN  = 2'd3;  // retire token, emit on last

  // value stack; entries below the count are the live values
  logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
  logic [WORD_W-1:0] lower_value;

  logic [1:0]        state, state_next;
  logic [CNT_W-1:0]  stack_count, count_next;
  logic [2:0]        error_latch, error_next;
  logic [WORD_W-1:0] top_value, top_next;
  logic [2:0]        op_reg;
  logic              last_reg;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [WORD_W-1:0] mem_wd;
  logic              rd_en;
  logic [CNT_W-1:0]  count_less2;

  logic              res_wr;
  logic [WORD_W-1:0] res_val;
  logic              out_load;
  logic [WORD_W-1:0] out_value_next;
  logic [2:0]        out_status_next;

  // operand views: right operand is the cached top, left comes from memory
  logic [WORD_W:0]   add_sum, sub_sum;
  logic [WORD_W-1:0] add_sat, sub_sat;
  logic [WORD_W-1:0] mag_l, mag_r, int_r;
  logic              neg_md;

  // shared unit
  pfx_req_t          req;
  logic [WORD_W-1:0] unit_opb;
  logic [NUM_W-1:0]  unit_lo_init;
  logic              unit_done;
  logic [WORD_W-1:0] unit_hi;
  logic [NUM_W-1:0]  unit_lo;
  logic [MAG_W-1:0]  prod, prod_sh;
  logic [WORD_W-1:0] mod_mag;
  logic [WORD_W-1:0] unit_res;

  assign token_stall = (state != S_IDLE);
  assign count_less2 = stack_count - CNT_W'(2);

  // saturating add and subtract
  always_comb begin
    add_sum = {lower_value[WORD_W-1], lower_value} + {top_value[WORD_W-1], top_value};
    sub_sum = {lower_value[WORD_W-1], lower_value} - {top_value[WORD_W-1], top_value};
    if (add_sum[WORD_W] != add_sum[WORD_W-1])
      add_sat = add_sum[WORD_W] ? NEG_LIMIT : POS_LIMIT;
    else
      add_sat = add_sum[WORD_W-1:0];
    if (sub_sum[WORD_W] != sub_sum[WORD_W-1])
      sub_sat = sub_sum[WORD_W] ? NEG_LIMIT : POS_LIMIT;
    else
      sub_sat = sub_sum[WORD_W-1:0];
  end

  // operand magnitudes and the load values for the shared unit
  always_comb begin
    mag_l  = mag_of(lower_value);
    mag_r  = mag_of(top_value);
    int_r  = mag_r >> FRACTION_BITS;
    neg_md = lower_value[WORD_W-1] ^ top_value[WORD_W-1];
    priority if (op_reg == OP_MUL) begin
      unit_opb     = mag_l;
      unit_lo_init = NUM_W'(mag_r);
    end else if (op_reg == OP_MOD) begin
      // integer parts only
      unit_opb     = int_r;
      unit_lo_init = NUM_W'(mag_l >> FRACTION_BITS);
    end else begin
      unit_opb     = mag_r;
      unit_lo_init = NUM_W'(mag_l) << FRACTION_BITS;
    end
  end

  // unit result back in fixed point
  always_comb begin
    prod    = {unit_hi, unit_lo[NUM_W-1 -: WORD_W]};
    prod_sh = prod >> FRACTION_BITS;
    // remainder is below the integer divisor, so the shift cannot overflow
    mod_mag = unit_hi << FRACTION_BITS;
    priority if (op_reg == OP_MUL)
      unit_res = from_mag(neg_md, prod_sh);
    else if (op_reg == OP_MOD)
      unit_res = lower_value[WORD_W-1] ? (~mod_mag + WORD_W'(1)) : mod_mag;
    else
      unit_res = from_mag(neg_md, MAG_W'(unit_lo));
  end

  // sequencer
  always_comb begin
    state_next      = state;
    count_next      = stack_count;
    error_next      = error_latch;
    top_next        = top_value;
    mem_we          = 1'b0;
    mem_wa          = stack_count[IDX_W-1:0];
    mem_wd          = token_value;
    rd_en           = 1'b0;
    req             = '0;
    res_wr          = 1'b0;
    res_val         = add_sat;
    out_load        = 1'b0;
    out_value_next  = '0;
    out_status_next = ST_OK;

    unique case (state)
      S_IDLE: begin
        if (token_valid) begin
          state_next = S_FIN;
          if (error_latch == ST_OK) begin
            if (kind == KIND_OPERAND) begin
              if (stack_count >= CNT_W'(STACK_DEPTH)) begin
                error_next = ST_OVERFLOW;
              end else begin
                mem_we     = 1'b1;
                top_next   = token_value;
                count_next = stack_count + CNT_W'(1);
              end
            end else if (stack_count < CNT_W'(2)) begin
              error_next = ST_MISSING;
            end else begin
              rd_en      = 1'b1;
              state_next = S_OPND;
            end
          end
        end
      end

      S_OPND: begin
        state_next = S_FIN;
        unique case (op_reg)
          OP_ADD: begin
            res_wr  = 1'b1;
            res_val = add_sat;
          end
          OP_SUB: begin
            res_wr  = 1'b1;
            res_val = sub_sat;
          end
          OP_MUL: begin
            req.start  = 1'b1;
            req.mul    = 1'b1;
            state_next = S_WAIT;
          end
          OP_DIV: begin
            if (top_value == '0) begin
              error_next = ST_DIV_ZERO;
            end else begin
              req.start  = 1'b1;
              state_next = S_WAIT;
            end
          end
          OP_MOD: begin
            if (int_r == '0) begin
              error_next = ST_MOD_ZERO;
            end else begin
              req.start  = 1'b1;
              state_next = S_WAIT;
            end
          end
          default: begin
            error_next = ST_ILLEGAL;
          end
        endcase
      end

      S_WAIT: begin
        if (unit_done) begin
          res_wr     = 1'b1;
          res_val    = unit_res;
          state_next = S_FIN;
        end
      end

      S_FIN: begin
        if (!last_reg) begin
          state_next = S_IDLE;
        end else if (!result_valid || !result_stall) begin
          out_load = 1'b1;
          priority if (error_latch != ST_OK) begin
            out_status_next = error_latch;
          end else if (stack_count == '0) begin
            out_status_next = ST_EMPTY;
          end else begin
            out_value_next = top_value;
          end
          count_next = '0;
          error_next = ST_OK;
          state_next = S_IDLE;
        end
      end
    endcase

    // operator result replaces the two operands
    if (res_wr) begin
      mem_we     = 1'b1;
      mem_wa     = count_less2[IDX_W-1:0];
      mem_wd     = res_val;
      top_next   = res_val;
      count_next = stack_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stack_count  <= '0;
      error_latch  <= ST_OK;
      result_valid <= 1'b0;
    end else begin
      state       <= state_next;
      stack_count <= count_next;
      error_latch <= error_next;
      if (out_load) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_value <= top_next;
    if (token_valid && !token_stall) begin
      op_reg   <= op_code;
      last_reg <= last_token;
    end
    if (out_load) begin
      result_value <= out_value_next;
      status       <= out_status_next;
    end
  end

  // stack memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_wa] <= mem_wd;
    if (rd_en) lower_value <= stack_mem[count_less2[IDX_W-1:0]];
  end

  pfx_shift_unit #(
    .NUM_W(NUM_W)
  ) u_unit (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .opb    (unit_opb),
    .lo_init(unit_lo_init),
    .done   (unit_done),
    .hi     (unit_hi),
    .lo     (unit_lo)
  );

endmodule

`default_nettype wire

// ===== design/pfx_shift_unit.sv =====
// ----------------------------------------------------------------------------
// pfx_shift_unit: shared iterative multiply / divide unit
// one bit per cycle, one shared 50-bit add/subtract for both modes
// ----------------------------------------------------------------------------
`default_nettype none

module pfx_shift_unit
  import pfx_pkg::*;
#(
  parameter int NUM_W = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pfx_req_t          req,
  input  wire logic [WORD_W-1:0] opb,
  input  wire logic [NUM_W-1:0]  lo_init,
  output logic                   done,
  output logic [WORD_W-1:0]      hi,
  output logic [NUM_W-1:0]       lo
);

  localparam int ITER_W = $clog2(NUM_W + 1);

  logic                busy;
  logic                mul;
  logic [ITER_W-1:0]   iter;
  logic [WORD_W-1:0]   b_reg;
  logic [WORD_W:0]     shifted;
  logic [WORD_W+1:0]   x_op;
  logic [WORD_W+1:0]   y_op;
  logic [WORD_W+1:0]   sum;
  logic                ge;
  logic [WORD_W-1:0]   hi_next;
  logic [NUM_W-1:0]    lo_next;

  always_comb begin
    shifted = {hi, lo[NUM_W-1]};
    x_op    = mul ? {2'b00, hi} : {1'b0, shifted};
    y_op    = (mul && !lo[0]) ? '0 : {2'b00, b_reg};
    // shared adder: add for multiply, subtract for divide
    sum     = x_op + (mul ? y_op : ~y_op) + (WORD_W+2)'(!mul);
    ge      = !sum[WORD_W+1];
    if (mul) begin
      hi_next = sum[WORD_W:1];
      lo_next = {sum[0], lo[NUM_W-1:1]};
    end else begin
      hi_next = ge ? sum[WORD_W-1:0] : shifted[WORD_W-1:0];
      lo_next = {lo[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        iter <= req.mul ? ITER_W'(WORD_W) : ITER_W'(NUM_W);
      end else if (busy) begin
        iter <= iter - ITER_W'(1);
        if (iter == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mul   <= req.mul;
      b_reg <= opb;
      hi    <= '0;
      lo    <= lo_init;
    end else if (busy) begin
      hi <= hi_next;
      lo <= lo_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/pfx_checker.sv =====
// ----------------------------------------------------------------------------
// pfx_checker: port-level checks of the postfix evaluator
// result channel behavior and token turnaround, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module pfx_checker
  import pfx_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              token_valid,
  input wire logic              token_stall,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire logic [WORD_W-1:0] result_value,
  input wire logic [2:0]        status
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(result_value) && $stable(status))
    else $error("stalled result changed");

  // error and empty results carry a zero value
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != ST_OK) |-> (result_value == '0))
    else $error("nonzero value with error status");

  // status 7 is never produced
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status != 3'd7))
    else $error("undefined status code");

  // every accepted request makes the token side busy in the cycle after
  a_token_busy: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_stall |=> token_stall)
    else $error("token accepted back to back");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind postfix_expression_evaluator pfx_checker u_pfx_checker (.*);

`default_nettype wire

// ===== sim/postfix_expression_evaluator_tb.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_tb: self-checking bench of the postfix evaluator
// directed corner expressions, then random token streams with idle gaps on both
// channels; every result is matched in order against a cycle-free prediction
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_expression_evaluator_tb;
  import pfx_pkg::*;

  localparam int STACK_LIMIT = 16;
  localparam int FRAC        = 16;
  localparam int WIDE        = 2 * WORD_W;

  // operator codes past modulo are all illegal
  localparam logic [2:0] OP_FIRST_ILLEGAL = 3'd5;
  localparam logic [2:0] OP_LAST_ILLEGAL  = 3'd7;

  localparam int          TOKEN_TARGET   = 1100;
  localparam int          PRESSURE_AFTER = 300;
  localparam int          HOLD_CYCLES    = 500;
  localparam int          DRAIN_CYCLES   = 150;
  // room for the slowest legal run: long tokens, long gaps, long stalls
  localparam int unsigned CYCLE_LIMIT    = 800000;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [2:0]        code;
  } answer_t;

  // expected evaluation: own value stack, error latch and answers in order
  class postfix_calc;
    logic [WORD_W-1:0] slots [STACK_LIMIT];
    int unsigned       depth;
    logic [2:0]        latched;
    answer_t           answers_due[$];
    int unsigned       faults;

    function new();
      depth   = 0;
      latched = ST_OK;
      faults  = 0;
    endfunction

    function logic [WORD_W-1:0] abs_word(input logic [WORD_W-1:0] w);
      return w[WORD_W-1] ? -w : w;
    endfunction

    function logic [WORD_W-1:0] signed_from_mag(input logic neg,
                                                input logic [WIDE-1:0] m);
      if (neg) return (m > WIDE'(NEG_LIMIT)) ? NEG_LIMIT : WORD_W'(-m);
      return (m > WIDE'(POS_LIMIT)) ? POS_LIMIT : m[WORD_W-1:0];
    endfunction

    function logic [WORD_W-1:0] clip_sum(input logic [WORD_W-1:0] a,
                                         input logic [WORD_W-1:0] b,
                                         input logic minus);
      logic [WORD_W:0] s;
      s = minus ? {a[WORD_W-1], a} - {b[WORD_W-1], b}
                : {a[WORD_W-1], a} + {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? NEG_LIMIT : POS_LIMIT;
      return s[WORD_W-1:0];
    endfunction

    // one accepted request: evaluate it, queue the answer on a last token
    function void take_token(input logic k, input logic [WORD_W-1:0] v,
                             input logic [2:0] op, input logic l);
      logic [WORD_W-1:0] rhs, lhs, outcome, ia, ib;
      logic [WIDE-1:0]   wide;
      answer_t           due;
      outcome = '0;
      if (latched == ST_OK) begin
        if (k == KIND_OPERAND) begin
          if (depth >= STACK_LIMIT) latched = ST_OVERFLOW;
          else begin
            slots[depth] = v;
            depth++;
          end
        end else if (depth < 2) begin
          latched = ST_MISSING;
        end else begin
          rhs = slots[depth-1];
          lhs = slots[depth-2];
          case (op)
            OP_ADD: outcome = clip_sum(lhs, rhs, 1'b0);
            OP_SUB: outcome = clip_sum(lhs, rhs, 1'b1);
            OP_MUL: begin
              wide = (WIDE'(abs_word(lhs)) * WIDE'(abs_word(rhs))) >> FRAC;
              outcome = signed_from_mag(lhs[WORD_W-1] ^ rhs[WORD_W-1], wide);
            end
            OP_DIV: begin
              if (rhs == '0) latched = ST_DIV_ZERO;
              else begin
                wide = (WIDE'(abs_word(lhs)) << FRAC) / WIDE'(abs_word(rhs));
                outcome = signed_from_mag(lhs[WORD_W-1] ^ rhs[WORD_W-1], wide);
              end
            end
            OP_MOD: begin
              ia = abs_word(lhs) >> FRAC;
              ib = abs_word(rhs) >> FRAC;
              if (ib == '0) latched = ST_MOD_ZERO;
              else begin
                outcome = (ia % ib) << FRAC;
                if (lhs[WORD_W-1]) outcome = -outcome;
              end
            end
            default: latched = ST_ILLEGAL;
          endcase
          if (latched == ST_OK) begin
            depth--;
            slots[depth-1] = outcome;
          end
        end
      end
      if (l) begin
        due.value = '0;
        if (latched != ST_OK) due.code = latched;
        else if (depth == 0) due.code = ST_EMPTY;
        else begin
          due.code  = ST_OK;
          due.value = slots[depth-1];
        end
        answers_due.push_back(due);
        depth   = 0;
        latched = ST_OK;
      end
    endfunction

    function void match_result(input logic [WORD_W-1:0] v, input logic [2:0] s);
      answer_t due;
      if (answers_due.size() == 0) begin
        $error("result with nothing pending: result_value %h status %0d", v, s);
        faults++;
        return;
      end
      due = answers_due.pop_front();
      if (v !== due.value) begin
        $error("result_value mismatch: expected %h, actual %h", due.value, v);
        faults++;
      end
      if (s !== due.code) begin
        $error("status mismatch: expected %0d, actual %0d", due.code, s);
        faults++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst          = 1'b1;
  logic              token_valid  = 1'b0;
  logic              token_stall;
  logic              kind         = KIND_OPERAND;
  logic [WORD_W-1:0] token_value  = '0;
  logic [2:0]        op_code      = OP_ADD;
  logic              last_token   = 1'b0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [WORD_W-1:0] result_value;
  logic [2:0]        status;

  postfix_calc calc;
  int          tokens_taken = 0;
  // cleared for some expressions so they go through with no sender gaps
  bit          sender_rests = 1'b1;

  postfix_expression_evaluator #(
    .STACK_DEPTH  (STACK_LIMIT),
    .FRACTION_BITS(FRAC)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .kind        (kind),
    .token_value (token_value),
    .op_code     (op_code),
    .last_token  (last_token),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_value(result_value),
    .status      (status)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // integer n as a fixed point word
  function automatic logic [WORD_W-1:0] fx_int(input int n);
    return WORD_W'(n) << FRAC;
  endfunction

  // one token request: optional gap, then hold it until the block takes it
  task automatic offer_token(input logic k, input logic [WORD_W-1:0] v,
                             input logic [2:0] op, input logic l);
    int roll, idle;
    roll = $urandom_range(0, 99);
    // mostly back to back, some short gaps, a few long ones
    if (!sender_rests || roll < 55) idle = 0;
    else if (roll < 88) idle = $urandom_range(1, 3);
    else if (roll < 97) idle = $urandom_range(4, 12);
    else idle = $urandom_range(25, 70);
    if (idle > 0) begin
      token_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    token_valid <= 1'b1;
    kind        <= k;
    token_value <= v;
    op_code     <= op;
    last_token  <= l;
    @(posedge clk);
    // payload stays put while the block stalls the request
    while (token_stall !== 1'b0) @(posedge clk);
    calc.take_token(k, v, op, l);
    tokens_taken++;
  endtask

  // operand request, op_code left as noise
  task automatic push_value(input logic [WORD_W-1:0] v, input logic l);
    offer_token(KIND_OPERAND, v, 3'($urandom), l);
  endtask

  // operator request, token_value left as noise
  task automatic apply_op(input logic [2:0] op, input logic l);
    offer_token(KIND_OPERATOR, WORD_W'({$urandom, $urandom}), op, l);
  endtask

  // accepted results go straight to the checker
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0)
      calc.match_result(result_value, status);
  end

  // result side back-pressure, plus one long hold while tokens keep coming
  initial begin : result_pacing
    int roll, span;
    bit held, level;
    held = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      roll = $urandom_range(0, 99);
      if (!held && tokens_taken >= PRESSURE_AFTER) begin
        // long hold: the block fills up and stalls its token side
        held  = 1'b1;
        level = 1'b1;
        span  = HOLD_CYCLES;
      end else if (roll < 55) begin
        level = 1'b0;
        span  = $urandom_range(1, 8);
      end else if (roll < 62) begin
        // stretch with no stalls at all
        level = 1'b0;
        span  = $urandom_range(60, 200);
      end else if (roll < 93) begin
        level = 1'b1;
        span  = $urandom_range(1, 4);
      end else begin
        level = 1'b1;
        span  = $urandom_range(15, 60);
      end
      result_stall <= level;
      repeat (span) @(posedge clk);
    end
  end

  // run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int                pick, operands, stacked;
    bit                pile_up, flip;
    logic [WORD_W-1:0] v;
    logic [2:0]        op;
    calc = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // --- directed corners ---
    // lone operand at the positive limit
    push_value(POS_LIMIT, 1'b1);
    // operator with an empty stack: missing operand
    apply_op(OP_ADD, 1'b1);
    // sum past the positive limit
    push_value(POS_LIMIT, 1'b0);
    push_value(POS_LIMIT, 1'b0);
    apply_op(OP_ADD, 1'b1);
    // difference past the negative limit
    push_value(NEG_LIMIT, 1'b0);
    push_value(POS_LIMIT, 1'b0);
    apply_op(OP_SUB, 1'b1);
    // product of two most negative values saturates high
    push_value(NEG_LIMIT, 1'b0);
    push_value(NEG_LIMIT, 1'b0);
    apply_op(OP_MUL, 1'b1);
    // divide by exact zero
    push_value(fx_int(3), 1'b0);
    push_value('0, 1'b0);
    apply_op(OP_DIV, 1'b1);
    // modulo by a pure fraction, negative dividend: modulo by zero
    push_value(WORD_W'(-29) << (FRAC - 2), 1'b0);
    push_value(WORD_W'(1) << (FRAC - 1), 1'b0);
    apply_op(OP_MOD, 1'b1);
    // illegal operator, then a token that must be ignored
    push_value(fx_int(5), 1'b0);
    push_value(fx_int(3), 1'b0);
    apply_op(OP_LAST_ILLEGAL, 1'b0);
    push_value(fx_int(9), 1'b1);
    // leftover value below the top, negative limit divided by three
    push_value(fx_int(1), 1'b0);
    push_value(NEG_LIMIT, 1'b0);
    push_value(fx_int(3), 1'b0);
    apply_op(OP_DIV, 1'b1);

    // --- random expressions ---
    while (tokens_taken < TOKEN_TARGET) begin
      sender_rests = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // noise: random tokens, random last marks, broken expressions
        repeat ($urandom_range(1, 5))
          offer_token(1'($urandom), WORD_W'({$urandom, $urandom}), 3'($urandom),
                      1'($urandom_range(0, 3) == 0));
      end else begin
        // well-formed postfix with random content
        if (pick < 80) operands = $urandom_range(1, 6);
        else if (pick < 93) operands = $urandom_range(7, 16);
        else operands = $urandom_range(17, 20);
        // deep ones push everything first: near-full stack or overflow
        pile_up = (operands > 16) || (operands > 6 && $urandom_range(0, 1) == 1);
        stacked = 0;
        while (operands > 0 || stacked > 1) begin
          if (operands > 0 && (stacked < 2 || pile_up || $urandom_range(0, 2) != 0))
          begin
            flip = 1'($urandom);
            case ($urandom_range(0, 11))
              0: v = POS_LIMIT;
              1: v = NEG_LIMIT;
              2: v = '0;
              3, 4: v = fx_int($urandom_range(1, 40));
              // up to four: modulo by zero comes up often
              5: v = WORD_W'($urandom_range(0, 4 << FRAC));
              6, 7: v = WORD_W'($urandom);
              default: v = WORD_W'({$urandom, $urandom});
            endcase
            if (flip) v = -v;
            operands--;
            stacked++;
            push_value(v, operands == 0 && stacked == 1);
          end else begin
            if ($urandom_range(0, 19) == 0)
              op = 3'($urandom_range(OP_FIRST_ILLEGAL, OP_LAST_ILLEGAL));
            else
              op = 3'($urandom_range(OP_ADD, OP_MOD));
            stacked--;
            apply_op(op, operands == 0 && stacked == 1);
          end
        end
      end
    end
    token_valid <= 1'b0;

    // drain, then leave room for any stray result
    while (calc.answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (calc.faults == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
